@@ rtl/sspq_pkg.sv @@
`default_nettype none
package sspq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int KEY_BITS    = 16;
	localparam int TAG_BITS    = 8;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int IN_BITS  = 2 * KEY_BITS + TAG_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + KEY_BITS + TAG_BITS + 2 + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SHIFT,
		S_PLACE,
		S_DONE
	} state_t;

	// store port request: one write and one read address per cycle
	typedef struct packed {
		logic                we;
		logic [IDX_W-1:0]    waddr;
		logic [KEY_BITS-1:0] wkey;
		logic [TAG_BITS-1:0] wtag;
		logic [IDX_W-1:0]    raddr;
	} mem_req_t;

	// result beat, first member in the highest bits
	typedef struct packed {
		logic [CNT_W-1:0]    occupancy;
		status_t             status;
		logic [TAG_BITS-1:0] tag;
		logic [KEY_BITS-1:0] key;
		logic                valid;
	} result_t;

	// logical queue slot to physical store index, circular from the head
	function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] lidx);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, lidx};
		if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/stable_sorted_priority_queue_core.sv @@
// Stable min-priority queue of (key, tag) pairs, kept sorted in a circular store.
// Input stream s_*: s_tuser is the mode (0 push, 1 pop); s_tdata carries
// base_key, key_increment and item_tag. A push stores base_key + key_increment,
// saturated, behind every entry with an equal or smaller key, so ties leave FIFO.
// Output stream m_*: one result beat per input beat with popped_valid,
// popped_key, popped_tag, status (0 ok, 1 full, 2 empty) and occupancy.
// Sequencing: a pop reads the head entry and advances the head, then its beat
// is loaded into the output register. A push walks the store
// from the tail, one entry a cycle through a single comparator, moving up each
// entry with a larger key (at most 31 of them), then writes the new entry into the
// freed slot. Rejected operations go straight to loading their beat. s_tready
// is high only while the sequencer is idle, so one item is in work at a time.
// The result sits in an output register; the next item is taken while it waits,
// and its result waits in turn until m_tready frees that register.
// Reset empties the queue and drops any pending result; the store itself is
// not cleared, only entries below the occupancy are ever used.
`default_nettype none
module stable_sorted_priority_queue_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [sspq_pkg::IN_W-1:0]     s_tdata,  // base_key, key_increment, item_tag
	input  wire                           s_tuser,  // mode
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [sspq_pkg::OUT_W-1:0]    m_tdata   // popped_valid, popped_key, popped_tag,
	                                                // status, occupancy
);

	sspq_pkg::mem_req_t            req;
	sspq_pkg::result_t             res;
	sspq_pkg::result_t             out_q;
	logic                          out_valid_q;
	logic                          out_free;
	logic                          res_load;
	logic [sspq_pkg::KEY_BITS-1:0] rd_key;
	logic [sspq_pkg::TAG_BITS-1:0] rd_tag;

	assign out_free = !out_valid_q || m_tready;

	sspq_store u_store (
		.clk    (clk),
		.req    (req),
		.rd_key (rd_key),
		.rd_tag (rd_tag)
	);

	sspq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser),
		.in_data  (s_tdata),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res),
		.req      (req),
		.rd_key   (rd_key),
		.rd_tag   (rd_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sspq_pkg::OUT_W'(out_q);

	// a popped entry always reports ok
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.valid |-> out_q.status == sspq_pkg::STAT_OK)
		else $error("popped entry with non-ok status");

	// rejected beats carry zero key and tag
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != sspq_pkg::STAT_OK
		|-> !out_q.valid && out_q.key == '0 && out_q.tag == '0)
		else $error("rejected beat with payload");

	// a new result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_valid_q || m_tready)
		else $error("result overwrote a waiting beat");

	// occupancy never exceeds the store depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res.occupancy <= sspq_pkg::CNT_W'(sspq_pkg::QUEUE_DEPTH))
		else $error("occupancy beyond depth");

endmodule
`default_nettype wire

@@ rtl/sspq_store.sv @@
`default_nettype none
module sspq_store (
	input  wire                          clk,
	input  wire sspq_pkg::mem_req_t      req,
	output logic [sspq_pkg::KEY_BITS-1:0] rd_key,
	output logic [sspq_pkg::TAG_BITS-1:0] rd_tag
);

	logic [sspq_pkg::KEY_BITS-1:0] key_mem [sspq_pkg::QUEUE_DEPTH];
	logic [sspq_pkg::TAG_BITS-1:0] tag_mem [sspq_pkg::QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			key_mem[req.waddr] <= req.wkey;
			tag_mem[req.waddr] <= req.wtag;
		end
	end

	always_ff @(posedge clk) begin
		rd_key <= key_mem[req.raddr];
		rd_tag <= tag_mem[req.raddr];
	end

endmodule
`default_nettype wire

@@ rtl/sspq_seq.sv @@
`default_nettype none
module sspq_seq (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              in_mode,
	input  wire  [sspq_pkg::IN_W-1:0]        in_data,
	input  wire                              out_free,
	output logic                             res_load,
	output sspq_pkg::result_t                res,
	output sspq_pkg::mem_req_t               req,
	input  wire  [sspq_pkg::KEY_BITS-1:0]    rd_key,
	input  wire  [sspq_pkg::TAG_BITS-1:0]    rd_tag
);

	localparam int K = sspq_pkg::KEY_BITS;
	localparam int T = sspq_pkg::TAG_BITS;
	localparam int C = sspq_pkg::CNT_W;
	localparam int I = sspq_pkg::IDX_W;

	sspq_pkg::state_t state_q, state_d;
	logic [I-1:0] head_q, head_d;
	logic [C-1:0] count_q, count_d;
	logic [C-1:0] idx_q, idx_d;
	logic [K-1:0] new_key_q, new_key_d;
	logic [T-1:0] new_tag_q, new_tag_d;
	logic         rvalid_q, rvalid_d;
	logic [K-1:0] rkey_q, rkey_d;
	logic [T-1:0] rtag_q, rtag_d;
	sspq_pkg::status_t rstat_q, rstat_d;

	logic [K:0]   sum;
	logic [K-1:0] sat_key;
	logic         move_up;

	assign sum     = {1'b0, in_data[K-1:0]} + {1'b0, in_data[2*K-1:K]};
	assign sat_key = sum[K] ? {K{1'b1}} : sum[K-1:0];
	// the shared compare: stored entry strictly above the new key moves up one slot
	assign move_up = rd_key > new_key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sspq_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		new_key_q <= new_key_d;
		new_tag_q <= new_tag_d;
		rvalid_q  <= rvalid_d;
		rkey_q    <= rkey_d;
		rtag_q    <= rtag_d;
		rstat_q   <= rstat_d;
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		new_key_d = new_key_q;
		new_tag_d = new_tag_q;
		rvalid_d  = rvalid_q;
		rkey_d    = rkey_q;
		rtag_d    = rtag_q;
		rstat_d   = rstat_q;
		in_ready  = 1'b0;
		res_load  = 1'b0;
		req.we    = 1'b0;
		req.waddr = sspq_pkg::phys_idx(head_q, idx_q);
		req.wkey  = new_key_q;
		req.wtag  = new_tag_q;
		req.raddr = head_q;

		unique case (state_q)
			sspq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rvalid_d = 1'b0;
					rkey_d   = '0;
					rtag_d   = '0;
					rstat_d  = sspq_pkg::STAT_OK;
					if (in_mode == sspq_pkg::MODE_POP) begin
						if (count_q == '0) begin
							rstat_d = sspq_pkg::STAT_EMPTY;
							state_d = sspq_pkg::S_DONE;
						end else begin
							state_d = sspq_pkg::S_POP;
						end
					end else begin
						new_key_d = sat_key;
						new_tag_d = in_data[2*K+T-1:2*K];
						idx_d     = count_q;
						if (count_q == C'(sspq_pkg::QUEUE_DEPTH)) begin
							rstat_d = sspq_pkg::STAT_FULL;
							state_d = sspq_pkg::S_DONE;
						end else if (count_q == '0) begin
							state_d = sspq_pkg::S_PLACE;
						end else begin
							req.raddr = sspq_pkg::phys_idx(head_q, count_q - C'(1));
							state_d   = sspq_pkg::S_SHIFT;
						end
					end
				end
			end
			sspq_pkg::S_POP: begin
				rvalid_d = 1'b1;
				rkey_d   = rd_key;
				rtag_d   = rd_tag;
				head_d   = (head_q == I'(sspq_pkg::QUEUE_DEPTH - 1)) ? '0 : head_q + I'(1);
				count_d  = count_q - C'(1);
				state_d  = sspq_pkg::S_DONE;
			end
			sspq_pkg::S_SHIFT: begin
				// rd_* holds logical slot idx_q-1
				req.we = 1'b1;
				if (move_up) begin
					req.wkey = rd_key;
					req.wtag = rd_tag;
					idx_d    = idx_q - C'(1);
					if (idx_q == C'(1)) begin
						state_d = sspq_pkg::S_PLACE;
					end else begin
						req.raddr = sspq_pkg::phys_idx(head_q, idx_q - C'(2));
					end
				end else begin
					count_d = count_q + C'(1);
					state_d = sspq_pkg::S_DONE;
				end
			end
			sspq_pkg::S_PLACE: begin
				req.we  = 1'b1;
				count_d = count_q + C'(1);
				state_d = sspq_pkg::S_DONE;
			end
			sspq_pkg::S_DONE: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = sspq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sspq_pkg::S_IDLE;
			end
		endcase
	end

	assign res.occupancy = count_q;
	assign res.status    = rstat_q;
	assign res.tag       = rtag_q;
	assign res.key       = rkey_q;
	assign res.valid     = rvalid_q;

endmodule
`default_nettype wire

@@ dv/stable_sorted_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
module stable_sorted_priority_queue_core_tb;

	localparam int RANDOM_OPS  = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 48;
	localparam int N_DIRECTED  = 21;

	typedef logic [sspq_pkg::KEY_BITS-1:0] key_t;
	typedef logic [sspq_pkg::TAG_BITS-1:0] tag_t;

	typedef struct packed {
		key_t key;
		tag_t tag;
	} entry_t;

	typedef struct {
		logic                       mode;
		key_t                       base;
		key_t                       incr;
		tag_t                       tag;
		bit                         typed;
		sspq_pkg::status_t          status;
		logic [sspq_pkg::CNT_W-1:0] occupancy;
	} directed_op_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [sspq_pkg::IN_W-1:0]   s_tdata;  // base_key, key_increment, item_tag
	logic                        s_tuser;  // mode
	logic                        m_tvalid;
	logic                        m_tready;
	logic [sspq_pkg::OUT_W-1:0]  m_tdata;  // popped_valid, popped_key, popped_tag, status,
	                                       // occupancy

	entry_t            ordered_entries[$];
	sspq_pkg::result_t awaited_results[$];
	int                mismatch_count = 0;
	int                cycle_count    = 0;
	int                sender_idle_pct;
	int                receiver_idle_pct;

	// pushes and pops of an empty queue carry their expectation in the table, other pops come from the predictor
	directed_op_t directed_ops[N_DIRECTED] = '{
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b1, sspq_pkg::STAT_EMPTY, 6'd0},
		'{sspq_pkg::MODE_PUSH, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, sspq_pkg::STAT_OK,    6'd1},
		'{sspq_pkg::MODE_PUSH, 16'h0000, 16'h0000, 8'h00, 1'b1, sspq_pkg::STAT_OK,    6'd2},
		'{sspq_pkg::MODE_PUSH, 16'h8000, 16'h7FFF, 8'hAA, 1'b1, sspq_pkg::STAT_OK,    6'd3},
		'{sspq_pkg::MODE_PUSH, 16'hFFFE, 16'h0002, 8'h55, 1'b1, sspq_pkg::STAT_OK,    6'd4},
		'{sspq_pkg::MODE_PUSH, 16'h0005, 16'h0000, 8'h01, 1'b1, sspq_pkg::STAT_OK,    6'd5},
		'{sspq_pkg::MODE_PUSH, 16'h0000, 16'h0005, 8'h02, 1'b1, sspq_pkg::STAT_OK,    6'd6},
		'{sspq_pkg::MODE_PUSH, 16'h0003, 16'h0002, 8'h03, 1'b1, sspq_pkg::STAT_OK,    6'd7},
		'{sspq_pkg::MODE_PUSH, 16'h1234, 16'h0000, 8'h80, 1'b1, sspq_pkg::STAT_OK,    6'd8},
		'{sspq_pkg::MODE_POP,  16'hFFFF, 16'hFFFF, 8'hFF, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h5A5A, 16'hA5A5, 8'h5A, 1'b1, sspq_pkg::STAT_EMPTY, 6'd0},
		'{sspq_pkg::MODE_PUSH, 16'h00FF, 16'hFF00, 8'h7F, 1'b1, sspq_pkg::STAT_OK,    6'd1},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b0, sspq_pkg::STAT_OK,    6'd0},
		'{sspq_pkg::MODE_POP,  16'h0000, 16'h0000, 8'h00, 1'b1, sspq_pkg::STAT_EMPTY, 6'd0}
	};

	stable_sorted_priority_queue_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sorted insert behind equal keys, head removal; rejects leave the queue alone.
	function automatic sspq_pkg::result_t apply_queue_op(logic mode, key_t base, key_t incr,
		tag_t tag);
		sspq_pkg::result_t             res;
		logic [sspq_pkg::KEY_BITS:0]   sum;
		entry_t                        ent;
		int                            pos;
		res = '0;
		res.status = sspq_pkg::STAT_OK;
		if (mode == sspq_pkg::MODE_PUSH) begin
			if (ordered_entries.size() >= sspq_pkg::QUEUE_DEPTH) begin
				res.status = sspq_pkg::STAT_FULL;
			end else begin
				sum = {1'b0, base} + {1'b0, incr};
				ent.key = sum[sspq_pkg::KEY_BITS] ? {sspq_pkg::KEY_BITS{1'b1}}
					: sum[sspq_pkg::KEY_BITS-1:0];
				ent.tag = tag;
				pos = 0;
				while (pos < ordered_entries.size() && ordered_entries[pos].key <= ent.key)
					pos++;
				ordered_entries.insert(pos, ent);
			end
		end else begin
			if (ordered_entries.size() == 0) begin
				res.status = sspq_pkg::STAT_EMPTY;
			end else begin
				ent = ordered_entries.pop_front();
				res.valid = 1'b1;
				res.key   = ent.key;
				res.tag   = ent.tag;
			end
		end
		res.occupancy = sspq_pkg::CNT_W'(ordered_entries.size());
		return res;
	endfunction

	function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (mismatch_count < 10)
			$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want,
				got);
		mismatch_count++;
	endfunction

	// Drive one beat, hold it until taken, then book the expected result.
	task automatic send_op(input logic mode, input key_t base, input key_t incr, input tag_t tag,
		input bit typed, input sspq_pkg::result_t typed_res);
		sspq_pkg::result_t predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(sspq_pkg::IN_W - sspq_pkg::IN_BITS){1'b0}}, tag, incr, base};
		do @(posedge clk); while (!s_tready);
		predicted = apply_queue_op(mode, base, incr, tag);
		awaited_results.push_back(typed ? typed_res : predicted);
	endtask

	function automatic void set_idling(int sent);
		if (sent < (RANDOM_OPS + N_DIRECTED) / 3) begin
			sender_idle_pct   = 27;
			receiver_idle_pct = 75;
		end else if (sent < 2 * (RANDOM_OPS + N_DIRECTED) / 3) begin
			sender_idle_pct   = 75;
			receiver_idle_pct = 27;
		end else begin
			sender_idle_pct   = 0;
			receiver_idle_pct = 0;
		end
	endfunction

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin : result_check
		sspq_pkg::result_t got;
		sspq_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = sspq_pkg::result_t'(m_tdata[sspq_pkg::OUT_BITS-1:0]);
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result beat", 32'd0, 32'(m_tdata));
			end else begin
				want = awaited_results.pop_front();
				if (got.valid != want.valid)
					report_mismatch("popped_valid", 32'(want.valid), 32'(got.valid));
				if (got.key != want.key)
					report_mismatch("popped_key", 32'(want.key), 32'(got.key));
				if (got.tag != want.tag)
					report_mismatch("popped_tag", 32'(want.tag), 32'(got.tag));
				if (got.status != want.status)
					report_mismatch("status", 32'(want.status), 32'(got.status));
				if (got.occupancy != want.occupancy)
					report_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		sspq_pkg::result_t typed_res;
		int                sent;
		int                push_pct;
		int                burst_len;
		int                key_style;
		logic              mode;
		key_t              base;
		key_t              incr;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = sspq_pkg::MODE_PUSH;
		s_tdata  = '0;
		m_tready = 1'b0;
		sent     = 0;
		set_idling(0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ops[i]) begin
			typed_res           = '0;
			typed_res.status    = directed_ops[i].status;
			typed_res.occupancy = directed_ops[i].occupancy;
			set_idling(sent);
			send_op(directed_ops[i].mode, directed_ops[i].base, directed_ops[i].incr,
				directed_ops[i].tag, directed_ops[i].typed, typed_res);
			sent++;
		end

		// bursts leaning to push or pop so the queue runs full and empty often
		while (sent < N_DIRECTED + RANDOM_OPS) begin
			case ($urandom_range(2))
				0: push_pct = 90;
				1: push_pct = 50;
				default: push_pct = 10;
			endcase
			burst_len = $urandom_range(8, 60);
			key_style = $urandom_range(2);
			for (int n = 0; n < burst_len && sent < N_DIRECTED + RANDOM_OPS; n++) begin
				mode = ($urandom_range(99) < push_pct) ? sspq_pkg::MODE_PUSH
					: sspq_pkg::MODE_POP;
				case (key_style)
					// narrow keys: plenty of ties to show FIFO order
					0: begin
						base = key_t'($urandom_range(7));
						incr = key_t'($urandom_range(3));
					end
					// near the top: saturation
					1: begin
						base = key_t'($urandom_range(16'hFFFF, 16'hFF00));
						incr = key_t'($urandom_range(16'h01FF));
					end
					default: begin
						base = key_t'($urandom);
						incr = key_t'($urandom);
					end
				endcase
				set_idling(sent);
				send_op(mode, base, incr, tag_t'($urandom), 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sspq_pkg.sv
rtl/sspq_store.sv
rtl/sspq_seq.sv
rtl/stable_sorted_priority_queue_core.sv
dv/stable_sorted_priority_queue_core_tb.sv
